>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off during reset
`define ARPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ARPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/arpc_pkg.sv
package arpc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam int unsigned IP_W    = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEASE_W = 16;
  localparam int unsigned CFG_W   = 48;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [LEASE_W-1:0] LEASE_RESET = 16'd300;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_UPDATE = 3'd1,
    OP_LK_IP  = 3'd2,
    OP_LK_MAC = 3'd3,
    OP_TICK   = 3'd4
  } op_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_LOCAL_IP  = 2'd0,
    REG_LOCAL_MAC = 2'd1,
    REG_LEASE     = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } in_t;

  typedef struct packed {
    logic             hit;
    logic             from_local;
    logic [IP_W-1:0]  ip_result;
    logic [MAC_W-1:0] mac_result;
    logic [CNT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  localparam logic [IDX_W:0]   ENTRIES_X = (IDX_W + 1)'(ENTRIES);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(ENTRIES);

  // (a + b) mod ENTRIES for ring slots
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= ENTRIES_X) begin
      s = s - ENTRIES_X;
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

>>> hdl/arp_cache_table_unit.sv
// ARP cache: a ring of 16 IP/MAC/expiry entries, oldest at the head, served by
// one sequencer over an entry memory with one read port and one write port.
// Insert, unknown opcodes and lookups of the own address go straight to the
// result. A tick advances the time and drops expired entries from the head,
// one after the other, until the head entry is unexpired or the ring is empty.
// Update and lookup walk the valid entries one per cycle from the head; an
// update walks them all, a lookup stops at its first hit. The next item is
// taken as soon as the result sits in the output register.
`include "assert_macros.svh"

module arp_cache_table_unit import arpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_o
);

  entry_t mem_q [ENTRIES];
  entry_t rd_q;

  state_e state_q, state_d;
  in_t    item_q, item_d;
  out_t   res_q, res_d, outr_q, outr_d;
  logic   out_vld_q, out_vld_d;

  logic [IP_W-1:0]    local_ip_q;
  logic [MAC_W-1:0]   local_mac_q;
  logic [LEASE_W-1:0] lease_q;

  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TIME_W-1:0] now_q, now_d;

  logic [IDX_W-1:0] iss_slot_q, iss_slot_d;
  logic [CNT_W-1:0] iss_cnt_q, iss_cnt_d;
  logic [IDX_W-1:0] rd_slot_q, rd_slot_d;
  logic             rd_vld_q, rd_vld_d;

  logic             accept;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  logic             ins_full;
  logic [IDX_W-1:0] ins_head;
  logic [CNT_W-1:0] ins_cnt;
  logic             issue_more, rd_match, expired, out_free;
  logic [TIME_W-1:0] age;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_o       = outr_q;
  assign out_free    = !out_vld_q || !out_stall_i;

  assign ins_full = (cnt_q >= CNT_FULL);
  assign ins_head = ins_full ? slot_add(head_q, IDX_W'(1)) : head_q;
  assign ins_cnt  = ins_full ? CNT_FULL - CNT_W'(1) : cnt_q;

  assign issue_more = (iss_cnt_q < cnt_q);
  assign rd_match   = (item_q.opcode == OP_LK_MAC) ? (rd_q.mac == item_q.mac_addr)
                                                   : (rd_q.ip == item_q.ip_addr);
  assign age        = now_q - rd_q.expiry;
  assign expired    = (age != '0) && !age[TIME_W-1];

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_ip_q  <= '0;
      local_mac_q <= '0;
      lease_q     <= LEASE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOCAL_IP:  local_ip_q  <= cfg_wdata_i[IP_W-1:0];
        REG_LOCAL_MAC: local_mac_q <= cfg_wdata_i[MAC_W-1:0];
        REG_LEASE:     lease_q     <= cfg_wdata_i[LEASE_W-1:0];
        default: ;
      endcase
    end
  end

  // entry memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.opcode)
            OP_UPDATE: state_d = ST_SCAN;
            OP_LK_IP:  state_d = (in_i.ip_addr == local_ip_q) ? ST_DONE : ST_SCAN;
            OP_LK_MAC: state_d = (in_i.mac_addr == local_mac_q) ? ST_DONE : ST_SCAN;
            OP_TICK:   state_d = ST_TICK_RD;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && rd_match && (item_q.opcode != OP_UPDATE)) begin
          state_d = ST_DONE;
        end else if (!issue_more && !rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_TICK_RD:  state_d = (cnt_q == '0) ? ST_DONE : ST_TICK_CHK;
      ST_TICK_CHK: state_d = expired ? ST_TICK_RD : ST_DONE;
      ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    item_d     = item_q;
    res_d      = res_q;
    outr_d     = outr_q;
    out_vld_d  = out_vld_q && out_stall_i;
    head_d     = head_q;
    cnt_d      = cnt_q;
    now_d      = now_q;
    iss_slot_d = iss_slot_q;
    iss_cnt_d  = iss_cnt_q;
    rd_slot_d  = rd_slot_q;
    rd_vld_d   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = slot_add(ins_head, ins_cnt[IDX_W-1:0]);
    mem_wdata  = '{ip: in_i.ip_addr, mac: in_i.mac_addr,
                   expiry: now_q + TIME_W'(lease_q)};
    mem_raddr  = head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d     = in_i;
          res_d      = '0;
          iss_slot_d = head_q;
          iss_cnt_d  = '0;
          case (in_i.opcode)
            OP_INSERT: begin
              mem_we = 1'b1;
              head_d = ins_head;
              cnt_d  = ins_cnt + CNT_W'(1);
            end
            OP_LK_IP: begin
              if (in_i.ip_addr == local_ip_q) begin
                res_d.hit        = 1'b1;
                res_d.from_local = 1'b1;
                res_d.mac_result = local_mac_q;
              end
            end
            OP_LK_MAC: begin
              if (in_i.mac_addr == local_mac_q) begin
                res_d.hit        = 1'b1;
                res_d.from_local = 1'b1;
                res_d.ip_result  = local_ip_q;
              end
            end
            OP_TICK: now_d = now_q + TIME_W'(1);
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        mem_raddr = iss_slot_q;
        if (rd_vld_q && rd_match) begin
          case (item_q.opcode)
            OP_UPDATE: begin
              mem_we        = 1'b1;
              mem_waddr     = rd_slot_q;
              mem_wdata     = rd_q;
              mem_wdata.mac = item_q.mac_addr;
            end
            OP_LK_IP: begin
              res_d.hit        = 1'b1;
              res_d.mac_result = rd_q.mac;
            end
            default: begin
              res_d.hit       = 1'b1;
              res_d.ip_result = rd_q.ip;
            end
          endcase
        end
        if (issue_more && !(rd_vld_q && rd_match && (item_q.opcode != OP_UPDATE))) begin
          rd_vld_d   = 1'b1;
          rd_slot_d  = iss_slot_q;
          iss_slot_d = slot_add(iss_slot_q, IDX_W'(1));
          iss_cnt_d  = iss_cnt_q + CNT_W'(1);
        end
      end
      ST_TICK_CHK: begin
        if (expired) begin
          head_d = slot_add(head_q, IDX_W'(1));
          cnt_d  = cnt_q - CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          outr_d             = res_q;
          outr_d.entry_count = cnt_q;
          out_vld_d          = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      head_q    <= '0;
      cnt_q     <= '0;
      now_q     <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      now_q     <= now_d;
      rd_vld_q  <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    res_q      <= res_d;
    outr_q     <= outr_d;
    iss_slot_q <= iss_slot_d;
    iss_cnt_q  <= iss_cnt_d;
    rd_slot_q  <= rd_slot_d;
  end

  `ARPC_ASSERT(a_cnt_bound, cnt_q <= CNT_FULL, "entry count beyond ring size")
  `ARPC_ASSERT(a_busy_after_accept, accept |=> (state_q != ST_IDLE),
               "sequencer idle after a transfer in")
  `ARPC_ASSERT(a_rd_in_scan, rd_vld_q |-> (state_q == ST_SCAN),
               "entry read in flight outside a scan")
  `ARPC_ASSERT(a_local_implies_hit, out_vld_q |-> (outr_q.hit || !outr_q.from_local),
               "local answer without hit")

endmodule
